// ----- sv/sacwt_pkg.sv -----
// ----------------------------------------------------------------------------
// sacwt_pkg
// shared types, constants and helpers of the write-through cache core
// ----------------------------------------------------------------------------
`default_nettype none

package sacwt_pkg;

  // fixed widths of the item fields
  localparam int ADDR_W = 16;
  localparam int DATA_W = 32;

  // victim selection lfsr
  localparam int              LFSR_W    = 16;
  localparam logic [15:0]     LFSR_TAPS = 16'hB400;
  localparam logic [15:0]     LFSR_SEED = 16'hACE1;

  // access kinds
  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // one galois step: shift right, fold taps in when a one drops out
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- sv/sacwt_victim.sv -----
// ----------------------------------------------------------------------------
// sacwt_victim
// replacement lfsr and victim way selection (lfsr value modulo way count)
// ----------------------------------------------------------------------------
`default_nettype none

module sacwt_victim #(
  parameter int WAY_COUNT = 4
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             step,
  output logic                                             done,
  output logic [((WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1)-1:0] way
);

  localparam int WAY_BITS_C = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam bit WAY_POW2   = ((WAY_COUNT & (WAY_COUNT - 1)) == 0);
  localparam int LW         = sacwt_pkg::LFSR_W;
  // reciprocal of the way count scaled by 2^32, rounded up
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << 32) + 64'(WAY_COUNT) - 64'd1) / 64'(WAY_COUNT);
  localparam logic [32:0]   RECIP = RECIP_WIDE[32:0];
  localparam logic [LW-1:0] W_LW  = LW'(WAY_COUNT);

  logic [LW-1:0]   lfsr;
  logic [LW-1:0]   lfsr_nx;
  logic [LW-1:0]   held;
  logic [LW-1:0]   quo;
  logic [LW+32:0]  prod;
  logic            busy;
  logic            calc;

  assign lfsr_nx = sacwt_pkg::lfsr_next(lfsr);

  // quotient by reciprocal multiplication, exact for any 16-bit value
  assign prod = (LW + 33)'(held) * (LW + 33)'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= sacwt_pkg::LFSR_SEED;
      done <= 1'b0;
      busy <= 1'b0;
      calc <= 1'b0;
    end else begin
      done <= (step && WAY_POW2) || calc;
      busy <= step && !WAY_POW2;
      calc <= busy;
      if (step) begin
        lfsr <= lfsr_nx;
        if (WAY_POW2) begin
          way <= WAY_BITS_C'(lfsr_nx & LW'(WAY_COUNT - 1));
        end else begin
          held <= lfsr_nx;
        end
      end else if (calc) begin
        way <= WAY_BITS_C'(held - quo * W_LW);
      end
      if (busy) begin
        quo <= prod[LW+31:32];
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/set_assoc_write_through_cache_core.sv -----
// ----------------------------------------------------------------------------
// set_assoc_write_through_cache_core
// set-associative write-through cache with random replacement in front of
// a zero-initialized backing memory held inside the block
// ----------------------------------------------------------------------------
// One item at a time. After an item is accepted, a hit (read or write) goes
// through the lookup and respond states into the output register, which it
// enters once that register is free, and the next item can then be taken
// while the result may still wait on the output side. A read miss first
// draws the victim from the lfsr, then the line is copied one word per cycle
// through the single read port of the backing memory.
// A way count that is not a power of two adds a reciprocal multiplication
// to picking the victim. After reset the block runs a clearing pass over the
// 2^(ADDR_BITS-2) words of backing memory (16384 at default) that zeroes them
// and the tag store, and stalls requests until it ends.
// SET_COUNT and LINE_BYTES are taken to be powers of two.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_write_through_cache_core #(
  parameter int SET_COUNT  = 64,
  parameter int WAY_COUNT  = 4,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic                            op,
  input  logic [sacwt_pkg::ADDR_W-1:0]    address,
  input  logic [sacwt_pkg::DATA_W-1:0]    write_data,
  // response channel
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [sacwt_pkg::DATA_W-1:0]    read_data,
  output logic                            hit
);

  // geometry
  localparam int WORDS      = LINE_BYTES / 4;
  localparam int WORD_BITS  = $clog2(WORDS);
  localparam int OFF_BITS   = $clog2(LINE_BYTES);
  localparam int SET_LOG    = $clog2(SET_COUNT);
  localparam int SET_BITS   = (SET_LOG > 0) ? SET_LOG : 1;
  localparam int TAG_RAW    = ADDR_BITS - OFF_BITS - SET_LOG;
  localparam int TAG_BITS   = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int WAY_BITS   = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int MEM_BITS   = ADDR_BITS - 2;
  localparam int MEM_WORDS  = 1 << MEM_BITS;
  localparam int LINE_DEPTH = SET_COUNT * WORDS;
  localparam int LINE_BITS  = $clog2(LINE_DEPTH);
  localparam int AW         = (ADDR_BITS > sacwt_pkg::ADDR_W) ? ADDR_BITS : sacwt_pkg::ADDR_W;
  localparam logic [AW-1:0] ADDR_MASK = {AW{1'b1}} >> (AW - ADDR_BITS);
  localparam int DW         = sacwt_pkg::DATA_W;

  // one-hot sequencer
  typedef enum logic [5:0] {
    S_CLEAR   = 6'b000001,
    S_IDLE    = 6'b000010,
    S_LOOKUP  = 6'b000100,
    S_VICTIM  = 6'b001000,
    S_FILL    = 6'b010000,
    S_RESPOND = 6'b100000
  } state_t;

  state_t state, state_next;

  // storage: tag store (valid + tag per way), line data, backing memory
  logic [TAG_BITS:0] tag_mem  [SET_COUNT][WAY_COUNT];
  logic [DW-1:0]     line_mem [LINE_DEPTH][WAY_COUNT];
  logic [DW-1:0]     bk_mem   [MEM_WORDS];

  logic [TAG_BITS:0] tag_rd  [WAY_COUNT];
  logic [DW-1:0]     line_rd [WAY_COUNT];
  logic [DW-1:0]     bk_rd;

  // request decode straight off the ports
  logic [AW-1:0]        addr_m;
  logic [WORD_BITS-1:0] dec_word;
  logic [SET_BITS-1:0]  dec_set;
  logic [TAG_BITS-1:0]  dec_tag;
  logic [MEM_BITS-1:0]  dec_mem;

  // captured item
  logic                 op_q;
  logic [WORD_BITS-1:0] word_q;
  logic [SET_BITS-1:0]  set_q;
  logic [TAG_BITS-1:0]  tag_q;
  logic [MEM_BITS-1:0]  mem_q;
  logic [DW-1:0]        wdata_q;

  // lookup
  logic [WAY_COUNT-1:0] hit_vec;
  logic                 hit_any;
  logic [WAY_BITS-1:0]  hit_way;
  logic                 is_read;
  logic                 miss_step;

  // clearing pass
  logic [MEM_BITS-1:0]  clr_cnt;
  logic                 clr_last;

  // line fill
  logic [WORD_BITS:0]   fill_rd_cnt;
  logic                 fill_issue;
  logic                 fill_wr_valid;
  logic [WORD_BITS-1:0] fill_wr_idx;
  logic                 fill_last;
  logic [WAY_BITS-1:0]  victim_q;
  logic                 vic_done;
  logic [WAY_BITS-1:0]  vic_way;

  // result waiting for the output register
  logic [DW-1:0]        res_data;
  logic                 res_hit;
  logic                 rsp_free;
  logic                 accept;

  assign addr_m   = AW'(address) & ADDR_MASK;
  assign dec_word = WORD_BITS'(addr_m >> 2);
  assign dec_set  = SET_BITS'((addr_m >> OFF_BITS) & AW'(SET_COUNT - 1));
  assign dec_tag  = TAG_BITS'(addr_m >> (OFF_BITS + SET_LOG));
  assign dec_mem  = MEM_BITS'(addr_m >> 2);

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign is_read   = (op_q == sacwt_pkg::OP_READ);

  // tag compare over the ways of the set, lowest matching way wins
  always_comb begin
    hit_way = '0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      hit_vec[w] = tag_rd[w][TAG_BITS] && (tag_rd[w][TAG_BITS-1:0] == tag_q);
    end
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_BITS'(w);
      end
    end
  end
  assign hit_any   = |hit_vec;
  assign miss_step = (state == S_LOOKUP) && is_read && !hit_any;

  assign clr_last   = (clr_cnt == MEM_BITS'(MEM_WORDS - 1));
  assign fill_issue = (state == S_FILL) && (fill_rd_cnt < (WORD_BITS + 1)'(WORDS));
  assign fill_last  = fill_wr_valid && (fill_wr_idx == WORD_BITS'(WORDS - 1));

  // victim picker
  sacwt_victim #(
    .WAY_COUNT (WAY_COUNT)
  ) u_victim (
    .clk  (clk),
    .rst  (rst),
    .step (miss_step),
    .done (vic_done),
    .way  (vic_way)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_next = miss_step ? S_VICTIM : S_RESPOND;
      end
      S_VICTIM: begin
        if (vic_done) state_next = S_FILL;
      end
      S_FILL: begin
        if (fill_last) state_next = S_RESPOND;
      end
      S_RESPOND: begin
        if (rsp_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // tag store: read the whole set at accept, clear or fill one row/way
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int w = 0; w < WAY_COUNT; w++) begin
        tag_rd[w] <= tag_mem[dec_set][w];
      end
    end
    if ((state == S_CLEAR) && (clr_cnt < MEM_BITS'(SET_COUNT))) begin
      for (int w = 0; w < WAY_COUNT; w++) begin
        tag_mem[SET_BITS'(clr_cnt)][w] <= '0;
      end
    end else if ((state == S_FILL) && fill_last) begin
      tag_mem[set_q][victim_q] <= {1'b1, tag_q};
    end
  end

  // line data: the row holds one word of every way
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int w = 0; w < WAY_COUNT; w++) begin
        line_rd[w] <= line_mem[LINE_BITS'({dec_set, dec_word})][w];
      end
    end
    if ((state == S_LOOKUP) && !is_read && hit_any) begin
      line_mem[LINE_BITS'({set_q, word_q})][hit_way] <= wdata_q;
    end else if ((state == S_FILL) && fill_wr_valid) begin
      line_mem[LINE_BITS'({set_q, fill_wr_idx})][victim_q] <= bk_rd;
    end
  end

  // backing memory: zeroed by the clearing pass, written through on writes
  always_ff @(posedge clk) begin
    if (fill_issue) begin
      bk_rd <= bk_mem[{mem_q[MEM_BITS-1:WORD_BITS], fill_rd_cnt[WORD_BITS-1:0]}];
    end
    if (state == S_CLEAR) begin
      bk_mem[clr_cnt] <= '0;
    end else if ((state == S_LOOKUP) && !is_read) begin
      bk_mem[mem_q] <= wdata_q;
    end
  end

  // item capture, lookup result and line fill control
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_wr_valid <= 1'b0;
    end else begin
      fill_wr_valid <= fill_issue;
    end
    fill_wr_idx <= fill_rd_cnt[WORD_BITS-1:0];

    if (accept) begin
      op_q    <= op;
      word_q  <= dec_word;
      set_q   <= dec_set;
      tag_q   <= dec_tag;
      mem_q   <= dec_mem;
      wdata_q <= write_data;
    end

    if (state == S_LOOKUP) begin
      res_hit  <= hit_any;
      res_data <= (is_read && hit_any) ? line_rd[hit_way] : '0;
    end

    // the requested word is taken as it streams into the line
    if ((state == S_FILL) && fill_wr_valid && (fill_wr_idx == word_q)) begin
      res_data <= bk_rd;
    end

    if ((state == S_VICTIM) && vic_done) begin
      victim_q    <= vic_way;
      fill_rd_cnt <= '0;
    end else if (fill_issue) begin
      fill_rd_cnt <= fill_rd_cnt + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_RESPOND) && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if ((state == S_RESPOND) && rsp_free) begin
      read_data <= res_data;
      hit       <= res_hit;
    end
  end

endmodule

`default_nettype wire

// ----- sv/sacwt_checker.sv -----
// ----------------------------------------------------------------------------
// sacwt_checker
// port-level checks of the cache core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module sacwt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_stall,
  input logic                         rsp_valid,
  input logic                         rsp_stall,
  input logic [sacwt_pkg::DATA_W-1:0] read_data,
  input logic                         hit
);

  // a stalled item stays on the response port unchanged
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(read_data) && $stable(hit)))
    else $error("stalled response item changed or dropped");

  // reset starts the clearing pass: no item taken, no result shown
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (req_stall && !rsp_valid))
    else $error("request taken or response shown right after reset");

  // one item in work at a time: a new item is not taken in the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while the previous one is still at work");

  // a result is not shown while its item is still being looked up
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && !rsp_valid) |=> !rsp_valid)
    else $error("response shown without a finished item");

endmodule

bind set_assoc_write_through_cache_core sacwt_checker u_sacwt_checker (.*);

`default_nettype wire

// ----- sim/cache_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cache_checker
// watches both channels of the write-through cache core, keeps its own copy
// of tags, lines, backing memory and victim lfsr, and compares every result
// ----------------------------------------------------------------------------
module cache_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  input  logic                            req_stall,
  input  logic                            op,
  input  logic [sacwt_pkg::ADDR_W-1:0]    address,
  input  logic [sacwt_pkg::DATA_W-1:0]    write_data,
  input  logic                            rsp_valid,
  input  logic                            rsp_stall,
  input  logic [sacwt_pkg::DATA_W-1:0]    read_data,
  input  logic                            hit,
  output int                              mismatch_count,
  output int                              due_count,
  output int                              read_hits,
  output int                              read_misses,
  output int                              write_hits,
  output int                              write_misses,
  output int                              evictions
);

  typedef struct packed {
    logic [sacwt_pkg::DATA_W-1:0] read_data;
    logic                         hit;
  } cache_rsp_t;

  // 64 sets x 4 ways, 16 words per line, 16k words of backing memory
  logic                         way_ok    [256];
  logic [3:0]                   way_tg    [256];
  logic [sacwt_pkg::DATA_W-1:0] line_mem  [4096];
  logic [sacwt_pkg::DATA_W-1:0] back_mem  [16384];
  logic [sacwt_pkg::LFSR_W-1:0] victim_sr;

  cache_rsp_t due_rsp_q [$];

  assign due_count = due_rsp_q.size();

  function automatic cache_rsp_t apply_access(input sacwt_pkg::op_t o,
                                              input logic [sacwt_pkg::ADDR_W-1:0] a,
                                              input logic [sacwt_pkg::DATA_W-1:0] d);
    cache_rsp_t r;
    logic [5:0] set_idx;
    logic [3:0] tg;
    logic [3:0] word_idx;
    logic [7:0] slot;
    logic [1:0] vw;
    int         way;
    set_idx  = a[11:6];
    tg       = a[15:12];
    word_idx = a[5:2];
    way      = -1;
    for (int w = 0; w < 4; w++) begin
      if (way < 0 && way_ok[{set_idx, 2'(w)}] && way_tg[{set_idx, 2'(w)}] == tg) begin
        way = w;
      end
    end
    r.hit       = (way >= 0);
    r.read_data = '0;
    if (o == sacwt_pkg::OP_READ) begin
      if (way < 0) begin
        // galois step, victim from the low bits even if a way is free
        victim_sr = victim_sr[0] ? ((victim_sr >> 1) ^ sacwt_pkg::LFSR_TAPS)
                                 : (victim_sr >> 1);
        vw        = victim_sr[1:0];
        slot      = {set_idx, vw};
        if (way_ok[slot]) begin
          evictions++;
        end
        for (int i = 0; i < 16; i++) begin
          line_mem[{slot, 4'(i)}] = back_mem[{a[15:6], 4'(i)}];
        end
        way_ok[slot] = 1'b1;
        way_tg[slot] = tg;
        way          = vw;
        read_misses++;
      end else begin
        read_hits++;
      end
      r.read_data = line_mem[{set_idx, 2'(way), word_idx}];
    end else begin
      if (way >= 0) begin
        line_mem[{set_idx, 2'(way), word_idx}] = d;
        write_hits++;
      end else begin
        write_misses++;
      end
      back_mem[a[15:2]] = d;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    cache_rsp_t want;
    if (rst) begin
      for (int i = 0; i < 256; i++) begin
        way_ok[i] = 1'b0;
        way_tg[i] = '0;
      end
      for (int i = 0; i < 4096; i++) line_mem[i] = '0;
      for (int i = 0; i < 16384; i++) back_mem[i] = '0;
      victim_sr      = sacwt_pkg::LFSR_SEED;
      mismatch_count = 0;
      read_hits      = 0;
      read_misses    = 0;
      write_hits     = 0;
      write_misses   = 0;
      evictions      = 0;
      due_rsp_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (due_rsp_q.size() == 0) begin
          $display("%0t: result with nothing awaited, read_data %h hit %b",
                   $time, read_data, hit);
          mismatch_count++;
        end else begin
          want = due_rsp_q.pop_front();
          if (read_data !== want.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time, want.read_data, read_data);
            mismatch_count++;
          end
          if (hit !== want.hit) begin
            $display("%0t: hit expected %b actual %b", $time, want.hit, hit);
            mismatch_count++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        due_rsp_q.push_back(apply_access(sacwt_pkg::op_t'(op), address, write_data));
      end
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives reads and writes into the write-through cache core with random
// idling on both channels; a checker beside the core predicts and compares
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_ITEMS = 400;
  localparam int CALM_ITEMS   = 60;      // tail of the run without idling
  localparam int DRAIN_CYCLES = 40;

  logic                         clk = 1'b0;
  logic                         rst;

  // request side
  logic                         req_valid;
  logic                         req_stall;
  sacwt_pkg::op_t               req_op;
  logic [sacwt_pkg::ADDR_W-1:0] req_address;
  logic [sacwt_pkg::DATA_W-1:0] req_write_data;

  // response side
  logic                         rsp_valid;
  logic                         rsp_stall;
  logic [sacwt_pkg::DATA_W-1:0] rsp_read_data;
  logic                         rsp_hit;

  // set for the last part of the run: no gaps, no stalls
  logic                         calm;

  int mismatch_count, due_count;
  int read_hits, read_misses, write_hits, write_misses, evictions;
  int sent_count;

  always #5 clk = ~clk;

  set_assoc_write_through_cache_core DUT (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .op         (req_op),
    .address    (req_address),
    .write_data (req_write_data),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .read_data  (rsp_read_data),
    .hit        (rsp_hit)
  );

  cache_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .op             (req_op),
    .address        (req_address),
    .write_data     (req_write_data),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .read_data      (rsp_read_data),
    .hit            (rsp_hit),
    .mismatch_count (mismatch_count),
    .due_count      (due_count),
    .read_hits      (read_hits),
    .read_misses    (read_misses),
    .write_hits     (write_hits),
    .write_misses   (write_misses),
    .evictions      (evictions)
  );

  // present one item and hold it until the core takes it; an optional gap
  // with valid low comes first. called at a rising edge, returns at the edge
  // where the item was accepted, leaving valid high for a back-to-back item
  task automatic send_access(input sacwt_pkg::op_t o,
                             input logic [sacwt_pkg::ADDR_W-1:0] a,
                             input logic [sacwt_pkg::DATA_W-1:0] d);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid      <= 1'b1;
    req_op         <= o;
    req_address    <= a;
    req_write_data <= d;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent_count++;
  endtask

  // receiver stalls in random bursts, quiet once calm is set
  initial begin : rsp_idle
    int burst;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 13);
        rsp_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // watchdog: fails and ends a run that does not finish in time
  initial begin : watchdog
    #5ms;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : stimulus
    sacwt_pkg::op_t               o;
    logic [sacwt_pkg::ADDR_W-1:0] a;
    logic [sacwt_pkg::DATA_W-1:0] d;
    int                           sel;

    rst            <= 1'b1;
    calm           <= 1'b0;
    req_valid      <= 1'b0;
    req_op         <= sacwt_pkg::OP_READ;
    req_address    <= '0;
    req_write_data <= '0;
    sent_count     = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // cold read miss at address zero, write data ignored on a read
    send_access(sacwt_pkg::OP_READ,  16'h0000, 32'hFFFF_FFFF);
    // low two address bits ignored, now a hit
    send_access(sacwt_pkg::OP_READ,  16'h0003, 32'h1234_5678);
    // write miss at the top address with all ones, nothing allocated
    send_access(sacwt_pkg::OP_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
    // read miss fills the line and sees the written-through word
    send_access(sacwt_pkg::OP_READ,  16'hFFFC, 32'h0000_0000);
    // write hit updates both the line and memory
    send_access(sacwt_pkg::OP_WRITE, 16'hFFFE, 32'h0000_0000);
    send_access(sacwt_pkg::OP_READ,  16'hFFFD, 32'hFFFF_FFFF);
    send_access(sacwt_pkg::OP_WRITE, 16'h0004, 32'hA5A5_5A5A);
    send_access(sacwt_pkg::OP_READ,  16'h0004, 32'h0000_0000);
    // six tags into one set: victims drawn with free ways left, then evictions
    for (int t = 0; t < 6; t++) begin
      send_access(sacwt_pkg::OP_READ, {4'(t), 6'd5, 6'd0}, 32'h0000_0000);
    end
    send_access(sacwt_pkg::OP_READ,  {4'd0, 6'd5, 6'd8}, 32'h0000_0000);
    // write miss in a full set, then a read brings the line in
    send_access(sacwt_pkg::OP_WRITE, {4'd7, 6'd5, 6'd60}, 32'h8000_0001);
    send_access(sacwt_pkg::OP_READ,  {4'd7, 6'd5, 6'd60}, 32'h0000_0000);
    send_access(sacwt_pkg::OP_READ,  {4'd7, 6'd5, 6'd0},  32'h0000_0000);
    send_access(sacwt_pkg::OP_WRITE, 16'h0000, 32'h7FFF_FFFE);
    send_access(sacwt_pkg::OP_READ,  16'h0000, 32'h0000_0000);
    send_access(sacwt_pkg::OP_WRITE, 16'h8000, 32'h5555_AAAA);
    send_access(sacwt_pkg::OP_READ,  16'h8002, 32'h0000_0000);

    // ---- random part ----
    // mostly a hot region of four sets and eight tags so hits, misses and
    // evictions all happen often; the rest spans the whole address space
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS) begin
        calm <= 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        a = {4'($urandom_range(0, 7)), 6'($urandom_range(0, 3)), 6'($urandom)};
      end else begin
        a = 16'($urandom);
      end
      o = ($urandom_range(0, 1) == 1) ? sacwt_pkg::OP_WRITE : sacwt_pkg::OP_READ;
      case ($urandom_range(0, 7))
        0: d = '0;
        1: d = '1;
        default: d = $urandom;
      endcase
      send_access(o, a, d);
    end
    req_valid <= 1'b0;

    // ---- drain ----
    while (due_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d items sent; reads %0d hit / %0d miss, writes %0d hit / %0d miss",
             sent_count, read_hits, read_misses, write_hits, write_misses);
    $display("tb_top: %0d valid lines replaced by read misses", evictions);
    if (mismatch_count == 0 && due_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/sacwt_pkg.sv
sv/sacwt_victim.sv
sv/set_assoc_write_through_cache_core.sv
sv/sacwt_checker.sv
sim/cache_checker.sv
sim/tb_top.sv
